// ===== rtl/sitt_pkg.sv =====
// Shared types and constants for the sorted identifier translation table.
// Holds the operation codes, register indexes, sequencer states and the entry layout.
// Depends on nothing; every other file refers to it by scoped names.
package sitt_pkg;

  // Operation codes carried by in_operation.
  typedef enum logic [1:0] {
    OP_CLEAR     = 2'd0,
    OP_INSERT    = 2'd1,
    OP_TRANSLATE = 2'd2
  } op_t;

  // Configuration register indexes.
  localparam int CFG_INDEX_W = 1;
  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_TRANSLATE_ENABLE = 1'b0,
    CFG_UNKNOWN_MARKER   = 1'b1
  } cfg_index_t;

  localparam int ID_W = 32;
  localparam logic [ID_W-1:0] UNKNOWN_MARKER_RESET = 32'hDEAD_BEEF;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_INS_CMP,
    ST_INS_PUT,
    ST_SRCH
  } state_t;

  // One table entry: old identifier and its replacement.
  typedef struct packed {
    logic [ID_W-1:0] key;
    logic [ID_W-1:0] value;
  } entry_t;

endpackage

// ===== rtl/sitt_pair_ram.sv =====
// Entry memory of the translation table: one write port, one registered read port.
// Depends on sitt_pkg for the entry layout.
// Contents are undefined until written; the table count tells which entries are live.
module sitt_pair_ram #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic               clk,
  input  logic               we,
  input  logic [AW-1:0]      waddr,
  input  sitt_pkg::entry_t   wdata,
  input  logic [AW-1:0]      raddr,
  output sitt_pkg::entry_t   rdata
);

  sitt_pkg::entry_t mem [DEPTH];
  sitt_pkg::entry_t rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/sorted_id_translation_table.sv =====
// Channel   Ports                                         Transfer
// --------  --------------------------------------------  ------------------------------
// input     start, busy, in_operation/key/mapped_value    start high and busy low at clk
// result    out_valid, out_result_id/replaced/            out_valid high for one cycle
//           table_full/entry_total
// config    cfg_we, cfg_index, cfg_wdata                  cfg_we high at clk
//
// Clear, an unused code, a rejected insert and a translate that skips the search give their
// result in the cycle after the transfer. A translate probes the entry memory once a cycle.
// An insert shifts one entry a cycle through the memory's single write port.
// Reset clears the count only; there is no clearing pass.
// The receiver cannot stall; busy stays high until the result strobe is issued.
// Depends on sitt_pkg and sitt_pair_ram.
module sorted_id_translation_table #(
  parameter int TABLE_DEPTH = 256,
  localparam int IW = $clog2(TABLE_DEPTH),
  localparam int CW = $clog2(TABLE_DEPTH + 1)
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [1:0]                          in_operation,
  input  logic [sitt_pkg::ID_W-1:0]           in_key,
  input  logic [sitt_pkg::ID_W-1:0]           in_mapped_value,
  output logic                                out_valid,
  output logic [sitt_pkg::ID_W-1:0]           out_result_id,
  output logic                                out_replaced,
  output logic                                out_table_full,
  output logic [CW-1:0]                       out_entry_total,
  input  logic                                cfg_we,
  input  logic [sitt_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [sitt_pkg::ID_W-1:0]           cfg_wdata
);

  // Control state.
  sitt_pkg::state_t state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          enable_r;

  // Payload registers.
  logic [sitt_pkg::ID_W-1:0] marker_r;
  logic [sitt_pkg::ID_W-1:0] key_r, key_nxt;
  logic [sitt_pkg::ID_W-1:0] val_r, val_nxt;
  logic [IW-1:0]             ptr_r, ptr_nxt;
  logic [CW-1:0]             lo_r, lo_nxt;
  logic [CW-1:0]             hi_r, hi_nxt;
  logic [CW-1:0]             mid_r, mid_nxt;
  logic [sitt_pkg::ID_W-1:0] res_r, res_nxt;
  logic                      repl_r, repl_nxt;
  logic                      full_r, full_nxt;

  // Memory port signals.
  logic             mem_we;
  logic [IW-1:0]    mem_waddr;
  logic [IW-1:0]    mem_raddr;
  sitt_pkg::entry_t mem_wdata;
  sitt_pkg::entry_t mem_rdata;
  sitt_pkg::entry_t new_entry;

  // Shared decode of the probe that returns from memory.
  logic          accept;
  logic          is_full;
  logic          probe_eq;
  logic          probe_ge;
  logic [CW-1:0] lo_n, hi_n, mid_n, mid_first;
  logic [CW:0]   sum_n, sum_first;

  sitt_pair_ram #(
    .DEPTH (TABLE_DEPTH),
    .AW    (IW)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign busy      = (state_r != sitt_pkg::ST_IDLE);
  assign accept    = start && !busy;
  assign is_full   = (count_r == CW'(TABLE_DEPTH));
  assign new_entry = '{key: key_r, value: val_r};

  // Probe compare: insert shifts while the stored key is not below the new key.
  assign probe_eq = (key_r == mem_rdata.key);
  assign probe_ge = (mem_rdata.key >= key_r);

  // Search window is [lo, hi); the midpoint matches an inclusive bound rounded down.
  assign lo_n      = (key_r < mem_rdata.key) ? lo_r : (mid_r + CW'(1));
  assign hi_n      = (key_r < mem_rdata.key) ? mid_r : hi_r;
  assign sum_n     = {1'b0, lo_n} + {1'b0, hi_n} - (CW+1)'(1);
  assign mid_n     = sum_n[CW:1];
  assign sum_first = {1'b0, count_r} - (CW+1)'(1);
  assign mid_first = sum_first[CW:1];

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sitt_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (in_operation)
            sitt_pkg::OP_INSERT: begin
              if (!is_full) begin
                state_nxt = (count_r == '0) ? sitt_pkg::ST_INS_PUT : sitt_pkg::ST_INS_CMP;
              end
            end
            sitt_pkg::OP_TRANSLATE: begin
              if (enable_r && (count_r != '0)) begin
                state_nxt = sitt_pkg::ST_SRCH;
              end
            end
            default: ;
          endcase
        end
      end
      sitt_pkg::ST_INS_CMP: begin
        if (!probe_ge) begin
          state_nxt = sitt_pkg::ST_IDLE;
        end else if (ptr_r == IW'(1)) begin
          state_nxt = sitt_pkg::ST_INS_PUT;
        end
      end
      sitt_pkg::ST_INS_PUT: begin
        state_nxt = sitt_pkg::ST_IDLE;
      end
      sitt_pkg::ST_SRCH: begin
        if (probe_eq || !(lo_n < hi_n)) begin
          state_nxt = sitt_pkg::ST_IDLE;
        end
      end
      default: state_nxt = sitt_pkg::ST_IDLE;
    endcase
  end

  // Datapath, memory control and result values.
  always_comb begin
    count_nxt     = count_r;
    out_valid_nxt = 1'b0;
    key_nxt       = key_r;
    val_nxt       = val_r;
    ptr_nxt       = ptr_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    mid_nxt       = mid_r;
    res_nxt       = res_r;
    repl_nxt      = repl_r;
    full_nxt      = full_r;
    mem_we        = 1'b0;
    mem_waddr     = ptr_r;
    mem_wdata     = new_entry;
    mem_raddr     = ptr_r - IW'(1);
    unique case (state_r)
      sitt_pkg::ST_IDLE: begin
        if (accept) begin
          key_nxt  = in_key;
          val_nxt  = in_mapped_value;
          res_nxt  = '0;
          repl_nxt = 1'b0;
          full_nxt = 1'b0;
          unique case (in_operation)
            sitt_pkg::OP_CLEAR: begin
              count_nxt     = '0;
              out_valid_nxt = 1'b1;
            end
            sitt_pkg::OP_INSERT: begin
              if (is_full) begin
                full_nxt      = 1'b1;
                out_valid_nxt = 1'b1;
              end else begin
                // Start at the top of the table and read the last live entry.
                ptr_nxt   = count_r[IW-1:0];
                mem_raddr = count_r[IW-1:0] - IW'(1);
              end
            end
            sitt_pkg::OP_TRANSLATE: begin
              if (enable_r && (count_r != '0)) begin
                lo_nxt    = '0;
                hi_nxt    = count_r;
                mid_nxt   = mid_first;
                mem_raddr = mid_first[IW-1:0];
              end else begin
                res_nxt       = in_key;
                out_valid_nxt = 1'b1;
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      sitt_pkg::ST_INS_CMP: begin
        // Move the entry up one place, or drop the new pair into the gap.
        mem_we = 1'b1;
        if (probe_ge) begin
          mem_wdata = mem_rdata;
          ptr_nxt   = ptr_r - IW'(1);
          mem_raddr = ptr_r - IW'(2);
        end else begin
          count_nxt     = count_r + CW'(1);
          out_valid_nxt = 1'b1;
        end
      end
      sitt_pkg::ST_INS_PUT: begin
        mem_we        = 1'b1;
        count_nxt     = count_r + CW'(1);
        out_valid_nxt = 1'b1;
      end
      sitt_pkg::ST_SRCH: begin
        if (probe_eq) begin
          out_valid_nxt = 1'b1;
          if (mem_rdata.value != marker_r) begin
            res_nxt  = mem_rdata.value;
            repl_nxt = 1'b1;
          end else begin
            res_nxt = key_r;
          end
        end else if (!(lo_n < hi_n)) begin
          res_nxt       = key_r;
          out_valid_nxt = 1'b1;
        end else begin
          lo_nxt    = lo_n;
          hi_nxt    = hi_n;
          mid_nxt   = mid_n;
          mem_raddr = mid_n[IW-1:0];
        end
      end
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sitt_pkg::ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    key_r  <= key_nxt;
    val_r  <= val_nxt;
    ptr_r  <= ptr_nxt;
    lo_r   <= lo_nxt;
    hi_r   <= hi_nxt;
    mid_r  <= mid_nxt;
    res_r  <= res_nxt;
    repl_r <= repl_nxt;
    full_r <= full_nxt;
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b1;
      marker_r <= sitt_pkg::UNKNOWN_MARKER_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sitt_pkg::CFG_TRANSLATE_ENABLE: enable_r <= cfg_wdata[0];
        sitt_pkg::CFG_UNKNOWN_MARKER:   marker_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_result_id   = res_r;
  assign out_replaced    = repl_r;
  assign out_table_full  = full_r;
  assign out_entry_total = count_r;

`ifndef SYNTHESIS
  // The count never passes the table depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(TABLE_DEPTH))
    else $error("entry count exceeds table depth");

  // No result strobe while an operation is still in flight.
  a_no_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !out_valid)
    else $error("result strobe while busy");

  // The shift pointer never reaches the bottom while comparing.
  a_ptr_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sitt_pkg::ST_INS_CMP) |-> (ptr_r != '0))
    else $error("insert shift pointer underflow");

  // A rejected insert is reported only with a full table.
  a_full_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_table_full) |-> (out_entry_total == CW'(TABLE_DEPTH)))
    else $error("table_full reported below depth");

  // An insert that ends in the put state grows the table by exactly one entry.
  a_insert_grow: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sitt_pkg::ST_INS_PUT) |=> (count_r == $past(count_r) + CW'(1)))
    else $error("insert did not grow the table by one");
`endif

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for the sorted identifier translation table.
// Drives clear, insert, translate and unused-code commands and checks every result strobe.
// Depends on sitt_pkg and the sorted_id_translation_table RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_DEPTH = 256;
  localparam int COUNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int PRINT_LIMIT = 40;
  localparam logic [1:0] OP_RESERVED = 2'd3;

  // One command as presented on the input channel.
  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] key;
    logic [31:0] value;
    logic        wait_drain;
  } table_cmd_t;

  // One result as seen on the output channel.
  typedef struct packed {
    logic [31:0]        result_id;
    logic               replaced;
    logic               table_full;
    logic [COUNT_W-1:0] entry_total;
  } lookup_result_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         in_operation = sitt_pkg::OP_CLEAR;
  logic [31:0]        in_key = '0;
  logic [31:0]        in_mapped_value = '0;
  logic               out_valid;
  logic [31:0]        out_result_id;
  logic               out_replaced;
  logic               out_table_full;
  logic [COUNT_W-1:0] out_entry_total;
  logic               cfg_we = 1'b0;
  logic [sitt_pkg::CFG_INDEX_W-1:0] cfg_index = sitt_pkg::CFG_TRANSLATE_ENABLE;
  logic [31:0]        cfg_wdata = '0;

  // Predicted table contents and register copies.
  logic [31:0] pair_keys [TABLE_DEPTH];
  logic [31:0] pair_values [TABLE_DEPTH];
  int          pair_count = 0;
  logic        xlate_enable = 1'b1;
  logic [31:0] marker_value = sitt_pkg::UNKNOWN_MARKER_RESET;

  table_cmd_t     cmd_queue[$];
  lookup_result_t expected_results[$];
  table_cmd_t     cmd_on_port;
  int             sender_idle_pct = 0;
  int             issued_cmds = 0;
  int             mismatch_count = 0;
  int             quiet_cycles = 0;

  sorted_id_translation_table #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_operation   (in_operation),
    .in_key         (in_key),
    .in_mapped_value(in_mapped_value),
    .out_valid      (out_valid),
    .out_result_id  (out_result_id),
    .out_replaced   (out_replaced),
    .out_table_full (out_table_full),
    .out_entry_total(out_entry_total),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  always #1 clk = ~clk;

  // Applies one command to the predicted table and returns the result it should give.
  function automatic lookup_result_t predict_table_op(table_cmd_t cmd);
    lookup_result_t r;
    int pos;
    int k;
    int lo;
    int hi;
    int mid;
    int hit;
    r = '0;
    case (cmd.op)
      sitt_pkg::OP_CLEAR: pair_count = 0;
      sitt_pkg::OP_INSERT: begin
        if (pair_count >= TABLE_DEPTH) begin
          r.table_full = 1'b1;
        end else begin
          // New pair goes ahead of any entry with an equal key.
          pos = pair_count;
          while (pos > 0 && pair_keys[pos-1] >= cmd.key) pos--;
          for (k = pair_count; k > pos; k--) begin
            pair_keys[k] = pair_keys[k-1];
            pair_values[k] = pair_values[k-1];
          end
          pair_keys[pos] = cmd.key;
          pair_values[pos] = cmd.value;
          pair_count++;
        end
      end
      sitt_pkg::OP_TRANSLATE: begin
        r.result_id = cmd.key;
        if (xlate_enable) begin
          // Plain binary search with the midpoint rounded down.
          lo = 0;
          hi = pair_count - 1;
          hit = -1;
          while (lo <= hi && hit < 0) begin
            mid = (lo + hi) / 2;
            if (cmd.key == pair_keys[mid]) hit = mid;
            else if (cmd.key < pair_keys[mid]) hi = mid - 1;
            else lo = mid + 1;
          end
          if (hit >= 0 && pair_values[hit] != marker_value) begin
            r.result_id = pair_values[hit];
            r.replaced = 1'b1;
          end
        end
      end
      default: ;
    endcase
    r.entry_total = pair_count[COUNT_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatch_count < PRINT_LIMIT) $display("%0t ns: mismatch: %s", $time, what);
    mismatch_count++;
  endtask

  // Sender: presents the next command once the previous transfer is done.
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) expected_results.push_back(predict_table_op(cmd_on_port));
      if (!start || !busy) begin
        if (cmd_queue.size() != 0 &&
            !(cmd_queue[0].wait_drain && expected_results.size() != 0) &&
            $urandom_range(0, 99) >= sender_idle_pct) begin
          cmd_on_port = cmd_queue.pop_front();
          start <= 1'b1;
          in_operation <= cmd_on_port.op;
          in_key <= cmd_on_port.key;
          in_mapped_value <= cmd_on_port.value;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Result checker: each strobe is matched against the oldest prediction.
  always @(posedge clk) begin
    lookup_result_t want;
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result strobe with no command outstanding");
      end else begin
        want = expected_results.pop_front();
        if (out_result_id !== want.result_id)
          report_mismatch($sformatf("result_id got %h want %h", out_result_id, want.result_id));
        if (out_replaced !== want.replaced)
          report_mismatch($sformatf("replaced got %b want %b", out_replaced, want.replaced));
        if (out_table_full !== want.table_full)
          report_mismatch($sformatf("table_full got %b want %b", out_table_full,
                                    want.table_full));
        if (out_entry_total !== want.entry_total)
          report_mismatch($sformatf("entry_total got %0d want %0d", out_entry_total,
                                    want.entry_total));
      end
    end
  end

  // Watchdog: ends the run when no transfer happens for too long.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("sorted_id_translation_table test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic push_cmd(input logic [1:0] op, input logic [31:0] key,
                          input logic [31:0] value);
    table_cmd_t c;
    c.op = op;
    c.key = key;
    c.value = value;
    // Now and then the sender holds off until every result is back.
    c.wait_drain = ($urandom_range(0, 99) == 0);
    cmd_queue.push_back(c);
    issued_cmds++;
  endtask

  function automatic logic [31:0] pick_id();
    case ($urandom_range(0, 39))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000;
      3: return 32'h7FFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [31:0] pick_value(input logic [31:0] marker);
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 10) return marker;
    if (pick < 15) return 32'h0000_0000;
    if (pick < 20) return 32'hFFFF_FFFF;
    return $urandom();
  endfunction

  // A session clears the table, fills it, then looks keys up with some noise mixed in.
  task automatic add_session(input int n_ins, input int n_lookup, input logic [31:0] marker);
    logic [31:0] keys[$];
    logic [31:0] k;
    bit          narrow;
    int          pick;
    narrow = ($urandom_range(0, 3) == 0);
    push_cmd(sitt_pkg::OP_CLEAR, $urandom(), $urandom());
    repeat (n_ins) begin
      k = narrow ? 32'($urandom_range(0, 15)) : pick_id();
      push_cmd(sitt_pkg::OP_INSERT, k, pick_value(marker));
      keys.push_back(k);
    end
    repeat (n_lookup) begin
      pick = $urandom_range(0, 99);
      if (pick < 65 && keys.size() != 0) begin
        push_cmd(sitt_pkg::OP_TRANSLATE, keys[$urandom_range(0, keys.size() - 1)], $urandom());
      end else if (pick < 85) begin
        push_cmd(sitt_pkg::OP_TRANSLATE, pick_id(), $urandom());
      end else if (pick < 92) begin
        k = pick_id();
        push_cmd(sitt_pkg::OP_INSERT, k, pick_value(marker));
        keys.push_back(k);
      end else if (pick < 97) begin
        push_cmd(OP_RESERVED, $urandom(), $urandom());
      end else begin
        push_cmd(sitt_pkg::OP_CLEAR, $urandom(), $urandom());
      end
    end
  endtask

  // Returns once the sender has nothing left and the block has answered everything.
  task automatic wait_idle();
    do @(negedge clk);
    while (cmd_queue.size() != 0 || start || busy || expected_results.size() != 0);
  endtask

  task automatic write_reg(input sitt_pkg::cfg_index_t idx, input logic [31:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    if (idx == sitt_pkg::CFG_TRANSLATE_ENABLE) xlate_enable = data[0];
    else marker_value = data;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_phase(input int idle_pct, input logic enable, input logic [31:0] marker,
                           input int n_cmds, input bit fill);
    int first;
    wait_idle();
    write_reg(sitt_pkg::CFG_TRANSLATE_ENABLE, ($urandom() & 32'hFFFF_FFFE) | 32'(enable));
    write_reg(sitt_pkg::CFG_UNKNOWN_MARKER, marker);
    sender_idle_pct = idle_pct;
    first = issued_cmds;
    // A full session runs past the table depth so that inserts get rejected.
    if (fill) add_session(TABLE_DEPTH + 4, 30, marker);
    while (issued_cmds - first < n_cmds)
      add_session($urandom_range(1, 24), $urandom_range(4, 40), marker);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part under the reset register values.
    push_cmd(sitt_pkg::OP_TRANSLATE, 32'h0000_0000, 32'h0000_0000);
    push_cmd(OP_RESERVED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_cmd(sitt_pkg::OP_INSERT, 32'h8000_0000, sitt_pkg::UNKNOWN_MARKER_RESET);
    push_cmd(sitt_pkg::OP_INSERT, 32'hFFFF_FFFF, 32'h0000_0000);
    push_cmd(sitt_pkg::OP_INSERT, 32'h0000_0000, 32'hFFFF_FFFF);
    push_cmd(sitt_pkg::OP_INSERT, 32'h1234_5678, 32'h9ABC_DEF0);
    // Duplicate key: lands ahead of the earlier entry.
    push_cmd(sitt_pkg::OP_INSERT, 32'h1234_5678, 32'h0F0F_0F0F);
    push_cmd(sitt_pkg::OP_TRANSLATE, 32'h0000_0000, 32'hFFFF_FFFF);
    push_cmd(sitt_pkg::OP_TRANSLATE, 32'hFFFF_FFFF, 32'h0000_0000);
    // Stored value equals the unknown marker, so the key passes through.
    push_cmd(sitt_pkg::OP_TRANSLATE, 32'h8000_0000, 32'h0000_0000);
    push_cmd(sitt_pkg::OP_TRANSLATE, 32'h1234_5678, 32'h0000_0000);
    push_cmd(sitt_pkg::OP_TRANSLATE, 32'h0000_0005, 32'h0000_0000);
    push_cmd(sitt_pkg::OP_TRANSLATE, 32'h7FFF_FFFF, 32'h0000_0000);
    push_cmd(OP_RESERVED, 32'h5A5A_5A5A, 32'hA5A5_A5A5);
    push_cmd(sitt_pkg::OP_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_cmd(sitt_pkg::OP_TRANSLATE, 32'hFFFF_FFFF, 32'h0000_0000);
    push_cmd(sitt_pkg::OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_cmd(sitt_pkg::OP_TRANSLATE, 32'hFFFF_FFFF, 32'h0000_0000);

    // Random phases with differing sender gaps and register settings.
    run_phase(0, 1'b1, sitt_pkg::UNKNOWN_MARKER_RESET, 300, 1'b1);
    run_phase(86, 1'b0, $urandom(), 200, 1'b0);
    run_phase(0, 1'b1, 32'h0000_0000, 250, 1'b0);
    run_phase(25, 1'b1, 32'hFFFF_FFFF, 250, 1'b1);
    run_phase(86, 1'b1, sitt_pkg::UNKNOWN_MARKER_RESET, 250, 1'b0);

    wait_idle();
    repeat (20) @(posedge clk);
    if (expected_results.size() != 0) report_mismatch("results still outstanding at the end");
    if (mismatch_count == 0) begin
      $display("sorted_id_translation_table test passed");
    end else begin
      $display("sorted_id_translation_table test failed");
    end
    $finish;
  end

endmodule
